// ===== rtl/lsi_pkg.sv =====
// Shared types, constants and codes of the linear step interpolator.
// Depends on nothing; every other file but lsi_ram imports it.
`default_nettype none
package lsi_pkg;

	// Fixed geometry of the block
	localparam int AXES            = 3;
	localparam int FIELD_BITS      = 24;
	localparam int STEP_BITS       = 26;
	localparam int SPEED_BITS      = 16;
	localparam int SSTEP_BITS      = 12;
	localparam int PERIOD_BITS     = 24;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int POS_BITS_DEF    = 24;

	// Register reset values
	localparam logic [SPEED_BITS-1:0]  SPEED_MIN_RST  = 16'd1000;
	localparam logic [SPEED_BITS-1:0]  SPEED_MAX_RST  = 16'd20000;
	localparam logic [SSTEP_BITS-1:0]  SPEED_STEP_RST = 12'd10;
	localparam logic [PERIOD_BITS-1:0] PERIOD_NUM_RST = 24'd4200000;

	// Register indexes
	localparam logic [1:0] REG_SPEED_MIN  = 2'd0;
	localparam logic [1:0] REG_SPEED_MAX  = 2'd1;
	localparam logic [1:0] REG_SPEED_STEP = 2'd2;
	localparam logic [1:0] REG_PERIOD_NUM = 2'd3;

	// Result status codes
	localparam logic [1:0] STAT_IDLE   = 2'd0;
	localparam logic [1:0] STAT_RUN    = 2'd1;
	localparam logic [1:0] STAT_ACCEPT = 2'd2;
	localparam logic [1:0] STAT_FULL   = 2'd3;

	typedef struct packed {
		logic                         req_type;
		logic signed [FIELD_BITS-1:0] target_x;
		logic signed [FIELD_BITS-1:0] target_y;
		logic signed [FIELD_BITS-1:0] target_z;
	} item_t;

	typedef struct packed {
		logic [1:0]                   status;
		logic [AXES-1:0]              step_mask;
		logic [AXES-1:0]              dir_mask;
		logic                         drive_enable;
		logic [PERIOD_BITS-1:0]       tick_period;
		logic signed [FIELD_BITS-1:0] pos_x;
		logic signed [FIELD_BITS-1:0] pos_y;
		logic signed [FIELD_BITS-1:0] pos_z;
	} result_t;

	typedef struct packed {
		logic [SPEED_BITS-1:0]  speed_min;
		logic [SPEED_BITS-1:0]  speed_max;
		logic [SSTEP_BITS-1:0]  speed_step;
		logic [PERIOD_BITS-1:0] period_num;
	} cfg_t;

endpackage
`default_nettype wire

// ===== rtl/lsi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lsi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/lsi_div.sv =====
// Restoring divider, one quotient bit per cycle, for the tick period.
// Depends on lsi_pkg for widths.
`default_nettype none
module lsi_div
	import lsi_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [PERIOD_BITS-1:0] num,
	input  wire logic [SPEED_BITS-1:0]  den,
	output logic      [PERIOD_BITS-1:0] quot,
	output logic                        done
);

	localparam int CNTW = $clog2(PERIOD_BITS + 1);

	logic [PERIOD_BITS-1:0] sh_q;
	logic [SPEED_BITS-1:0]  rem_q;
	logic [CNTW-1:0]        cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [SPEED_BITS:0]    trial;
	logic                   fits;

	// Shift in the next numerator bit and try the subtract; a zero divisor yields all ones
	assign trial = {rem_q, sh_q[PERIOD_BITS-1]};
	assign fits  = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(PERIOD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits shift into the numerator register
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= {sh_q[PERIOD_BITS-2:0], fits};
			rem_q <= fits ? SPEED_BITS'(trial - {1'b0, den}) : trial[SPEED_BITS-1:0];
		end
	end

	assign quot = sh_q;
	assign done = done_q;

endmodule
`default_nettype wire

// ===== rtl/lsi_front.sv =====
// Front end: accepts request words and holds them in a two-word queue.
// Depends on lsi_pkg for the item type.
`default_nettype none
module lsi_front
	import lsi_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire item_t in_item,
	output logic       item_valid,
	input  wire logic  item_pop,
	output item_t      item
);

	item_t      fifo_q [2];
	logic [1:0] cnt_q;
	logic       wr_q;
	logic       rd_q;
	logic       push;

	assign in_stall   = (cnt_q == 2'd2);
	assign push       = in_valid && !in_stall;
	assign item_valid = (cnt_q != 2'd0);
	assign item       = fifo_q[rd_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (item_pop) begin
				rd_q <= !rd_q;
			end
			case ({push, item_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Hold accepted words
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= in_item;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lsi_back.sv =====
// Back end: move queue, step sequencer with shared multiplier, speed ramp, output word.
// Depends on lsi_pkg, lsi_ram and lsi_div.
`default_nettype none
module lsi_back
	import lsi_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int POS_BITS    = POS_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  item_valid,
	output logic       item_pop,
	input  wire item_t item,
	output logic       out_valid,
	input  wire logic  out_stall,
	output result_t    res
);

	localparam int AW  = $clog2(QUEUE_DEPTH);
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int DW  = POS_BITS + 1;
	localparam int EW  = AXES * DW + AXES + DW;
	localparam int OPW = (DW > STEP_BITS + 1) ? DW : STEP_BITS + 1;
	localparam int PW  = 2 * OPW;
	localparam int RW  = (DW > STEP_BITS) ? DW : STEP_BITS;
	localparam int KW  = $clog2(AXES);
	localparam int SPW = SPEED_BITS + SSTEP_BITS;

	typedef enum logic [15:0] {
		S_IDLE   = 16'b0000_0000_0000_0001,
		S_MOVE   = 16'b0000_0000_0000_0010,
		S_TICK   = 16'b0000_0000_0000_0100,
		S_LOAD   = 16'b0000_0000_0000_1000,
		S_LATCH  = 16'b0000_0000_0001_0000,
		S_ENDCHK = 16'b0000_0000_0010_0000,
		S_AXSEL  = 16'b0000_0000_0100_0000,
		S_MUL1   = 16'b0000_0000_1000_0000,
		S_MUL2   = 16'b0000_0001_0000_0000,
		S_CMP    = 16'b0000_0010_0000_0000,
		S_RAMP1  = 16'b0000_0100_0000_0000,
		S_RAMP2  = 16'b0000_1000_0000_0000,
		S_RAMP3  = 16'b0001_0000_0000_0000,
		S_DIV    = 16'b0010_0000_0000_0000,
		S_DIVW   = 16'b0100_0000_0000_0000,
		S_OUT    = 16'b1000_0000_0000_0000
	} state_t;

	state_t                 state_q;
	item_t                  item_q;
	logic [CW-1:0]          count_q;
	logic [AW-1:0]          head_q;
	logic [AW-1:0]          tail_q;
	logic [POS_BITS-1:0]    last_end_q [AXES];
	logic [POS_BITS-1:0]    pos_q      [AXES];
	logic [DW-1:0]          done_q     [AXES];
	logic [DW-1:0]          cur_delta_q [AXES];
	logic [AXES-1:0]        cur_dir_q;
	logic [DW-1:0]          cur_total_q;
	logic [AXES-1:0]        pending_q;
	logic [STEP_BITS-1:0]   master_q;
	logic [STEP_BITS-1:0]   real_q;
	logic [SPEED_BITS-1:0]  ramp_q;
	logic [SPEED_BITS-1:0]  speed_q;
	logic                   running_q;
	logic                   chain_q;
	logic                   hold_q;
	logic                   recheck_q;
	logic [KW-1:0]          k_q;
	logic [AXES-1:0]        steps_q;
	logic [1:0]             status_q;
	logic [PW-1:0]          pa_q;
	logic [PW-1:0]          pb_q;
	logic [SPW-1:0]         sp_q;
	logic                   out_valid_q;
	result_t                out_q;

	logic signed [FIELD_BITS-1:0] tin [AXES];
	logic [POS_BITS-1:0]    tgt  [AXES];
	logic [DW-1:0]          mag  [AXES];
	logic [AXES-1:0]        mdir;
	logic [DW-1:0]          mtotal;
	logic                   full;
	logic [AW-1:0]          head_nxt;
	logic [AW-1:0]          tail_nxt;
	logic                   ram_we;
	logic [EW-1:0]          ram_wdata;
	logic [EW-1:0]          ram_rdata;
	logic [DW-1:0]          s_cur;
	logic [DW-1:0]          d_cur;
	logic [OPW-1:0]         op_a;
	logic [OPW-1:0]         op_b;
	logic [PW-1:0]          mul;
	logic                   lt;
	logic                   last_axis;
	logic                   finish;
	logic [RW-1:0]          tot_e;
	logic [RW-1:0]          real_e;
	logic [RW-1:0]          remain;
	logic [SPW:0]           sp_sum;
	logic                   div_start;
	logic [PERIOD_BITS-1:0] div_quot;
	logic                   div_done;
	logic                   out_load;
	logic [POS_BITS+FIELD_BITS-1:0] pos_ext [AXES];

	assign tin[0] = item_q.target_x;
	assign tin[1] = item_q.target_y;
	assign tin[2] = item_q.target_z;

	// Per-axis delta from the last queued end, or from the live position when empty
	always_comb begin
		logic [POS_BITS+FIELD_BITS-1:0] ext_v;
		logic [POS_BITS-1:0]            refp;
		logic [DW-1:0]                  dsum;
		mtotal = '0;
		for (int k = 0; k < AXES; k++) begin
			ext_v  = {{POS_BITS{tin[k][FIELD_BITS-1]}}, tin[k]};
			tgt[k] = ext_v[POS_BITS-1:0];
			refp   = (count_q != '0) ? last_end_q[k] : pos_q[k];
			dsum   = {tgt[k][POS_BITS-1], tgt[k]} - {refp[POS_BITS-1], refp};
			mag[k] = dsum[DW-1] ? DW'(~dsum + 1'b1) : dsum;
			mdir[k] = !dsum[DW-1] && (dsum != '0);
			if (mag[k] > mtotal) begin
				mtotal = mag[k];
			end
		end
	end

	// Pack a queue entry: deltas, then direction bits, then the master step count
	always_comb begin
		for (int k = 0; k < AXES; k++) begin
			ram_wdata[k*DW +: DW] = mag[k];
		end
		ram_wdata[AXES*DW +: AXES]    = mdir;
		ram_wdata[AXES*DW+AXES +: DW] = mtotal;
	end

	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign ram_we   = (state_q == S_MOVE) && !full;
	assign head_nxt = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;

	lsi_ram #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (ram_wdata),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	// Shared multiplier: step threshold as s*total < (n+1)*d
	assign s_cur = done_q[k_q] + 1'b1;
	assign d_cur = cur_delta_q[k_q];
	assign op_a  = (state_q == S_MUL1) ? OPW'(s_cur) : OPW'({1'b0, master_q} + 1'b1);
	assign op_b  = (state_q == S_MUL1) ? OPW'(cur_total_q) : OPW'(d_cur);
	assign mul   = op_a * op_b;
	assign lt    = pa_q < pb_q;

	assign last_axis = (k_q == KW'(AXES - 1));
	assign finish    = (RW'(master_q) > RW'(cur_total_q)) && (pending_q == '0);

	// Ramp distance left
	assign tot_e  = RW'(cur_total_q);
	assign real_e = RW'(real_q);
	assign remain = (tot_e > real_e) ? tot_e - real_e : '0;
	assign sp_sum = (SPW + 1)'(cfg.speed_min) + (SPW + 1)'(sp_q);

	assign div_start = (state_q == S_DIV);

	lsi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (cfg.period_num),
		.den    (speed_q),
		.quot   (div_quot),
		.done   (div_done)
	);

	assign item_pop = (state_q == S_IDLE) && item_valid;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			pending_q   <= '0;
			master_q    <= STEP_BITS'(1);
			real_q      <= STEP_BITS'(1);
			ramp_q      <= '0;
			speed_q     <= SPEED_MIN_RST;
			running_q   <= 1'b0;
			chain_q     <= 1'b0;
			hold_q      <= 1'b0;
			recheck_q   <= 1'b0;
			k_q         <= '0;
			steps_q     <= '0;
			status_q    <= STAT_IDLE;
			out_valid_q <= 1'b0;
			for (int k = 0; k < AXES; k++) begin
				pos_q[k]  <= '0;
				done_q[k] <= '0;
			end
		end else begin
			// Load a new result word, or drop the one taken by the receiver
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						steps_q <= '0;
						state_q <= item.req_type ? S_MOVE : S_TICK;
					end
				end
				S_MOVE: begin
					if (full) begin
						status_q <= STAT_FULL;
					end else begin
						tail_q   <= tail_nxt;
						count_q  <= count_q + 1'b1;
						status_q <= STAT_ACCEPT;
					end
					state_q <= S_DIV;
				end
				S_TICK: begin
					if (count_q == '0) begin
						running_q <= 1'b0;
						status_q  <= STAT_IDLE;
						state_q   <= S_DIV;
					end else if (!running_q) begin
						running_q <= 1'b1;
						ramp_q    <= '0;
						speed_q   <= cfg.speed_min;
						chain_q   <= 1'b0;
						state_q   <= S_LOAD;
					end else begin
						state_q <= S_ENDCHK;
					end
				end
				S_LOAD: begin
					state_q <= S_LATCH;
				end
				S_LATCH: begin
					master_q <= STEP_BITS'(1);
					real_q   <= STEP_BITS'(1);
					for (int k = 0; k < AXES; k++) begin
						done_q[k]    <= '0;
						pending_q[k] <= (ram_rdata[k*DW +: DW] != '0);
					end
					if (chain_q) begin
						k_q      <= '0;
						hold_q   <= 1'b0;
						status_q <= STAT_RUN;
						state_q  <= S_AXSEL;
					end else begin
						state_q <= S_ENDCHK;
					end
				end
				S_ENDCHK: begin
					if (finish) begin
						head_q  <= head_nxt;
						count_q <= count_q - 1'b1;
						if (count_q == CW'(1)) begin
							running_q <= 1'b0;
							status_q  <= STAT_IDLE;
							state_q   <= S_DIV;
						end else begin
							chain_q <= 1'b1;
							state_q <= S_LOAD;
						end
					end else begin
						k_q      <= '0;
						hold_q   <= 1'b0;
						status_q <= STAT_RUN;
						state_q  <= S_AXSEL;
					end
				end
				S_AXSEL: begin
					if (pending_q[k_q]) begin
						recheck_q <= 1'b0;
						state_q   <= S_MUL1;
					end else if (last_axis) begin
						state_q <= S_RAMP1;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_MUL1: begin
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (!recheck_q && lt) begin
						// Take the step and move one count toward the target
						steps_q[k_q] <= 1'b1;
						done_q[k_q]  <= s_cur;
						pos_q[k_q]   <= cur_dir_q[k_q] ? pos_q[k_q] + 1'b1 : pos_q[k_q] - 1'b1;
					end
					if (!recheck_q && lt && (s_cur < d_cur)) begin
						recheck_q <= 1'b1;
						state_q   <= S_MUL1;
					end else begin
						if (!recheck_q && lt) begin
							pending_q[k_q] <= 1'b0;
						end
						if (recheck_q && lt) begin
							hold_q <= 1'b1;
						end
						if (last_axis) begin
							state_q <= S_RAMP1;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_AXSEL;
						end
					end
				end
				S_RAMP1: begin
					// Climb below the maximum speed while the ramp fits in the steps left, descend once it does not
					if (RW'(ramp_q) <= remain) begin
						if ((speed_q < cfg.speed_max) && (ramp_q != '1)) begin
							ramp_q <= ramp_q + 1'b1;
						end
					end else if (ramp_q != '0) begin
						ramp_q <= ramp_q - 1'b1;
					end
					state_q <= S_RAMP2;
				end
				S_RAMP2: begin
					state_q <= S_RAMP3;
				end
				S_RAMP3: begin
					speed_q <= (sp_sum > (SPW + 1)'(16'hFFFF)) ? '1 : sp_sum[SPEED_BITS-1:0];
					if (!hold_q && (master_q != '1)) begin
						master_q <= master_q + 1'b1;
					end
					if ((steps_q != '0) && (real_q != '1)) begin
						real_q <= real_q + 1'b1;
					end
					state_q <= S_DIV;
				end
				S_DIV: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output position: wrap to the field width
	always_comb begin
		for (int k = 0; k < AXES; k++) begin
			pos_ext[k] = {{FIELD_BITS{1'b0}}, pos_q[k]};
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (item_pop) begin
			item_q <= item;
		end
		if (ram_we) begin
			for (int k = 0; k < AXES; k++) begin
				last_end_q[k] <= tgt[k];
			end
		end
		if (state_q == S_LATCH) begin
			for (int k = 0; k < AXES; k++) begin
				cur_delta_q[k] <= ram_rdata[k*DW +: DW];
			end
			cur_dir_q   <= ram_rdata[AXES*DW +: AXES];
			cur_total_q <= ram_rdata[AXES*DW+AXES +: DW];
		end
		if (state_q == S_MUL1) begin
			pa_q <= mul;
		end
		if (state_q == S_MUL2) begin
			pb_q <= mul;
		end
		if (state_q == S_RAMP2) begin
			sp_q <= ramp_q * cfg.speed_step;
		end
		if (out_load) begin
			out_q.status       <= status_q;
			out_q.step_mask    <= steps_q;
			out_q.dir_mask     <= running_q ? cur_dir_q : '0;
			out_q.drive_enable <= running_q;
			out_q.tick_period  <= div_quot;
			out_q.pos_x        <= pos_ext[0][FIELD_BITS-1:0];
			out_q.pos_y        <= pos_ext[1][FIELD_BITS-1:0];
			out_q.pos_z        <= pos_ext[2][FIELD_BITS-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign res       = out_q;

	// A running move always has its entry in the queue
	a_run_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> (count_q != '0))
		else $error("running with empty move queue");

	// Pending axes only exist inside a running move
	a_pending_running: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q != '0) |-> running_q)
		else $error("axis pending while not running");

	// Queue never overfills
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("move queue count beyond depth");

	// Only a running tick reports steps
	a_steps_only_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.status != STAT_RUN)) |-> (out_q.step_mask == '0))
		else $error("step reported outside a running tick");

endmodule
`default_nettype wire

// ===== rtl/linear_step_interpolator_ramp_top.sv =====
// Top level of the three-axis linear step interpolator with speed ramp: APB registers,
// front queue and back sequencer. Depends on lsi_pkg, lsi_front and lsi_back.
//
// Each request word is either a timer tick or a linear move, and every word gives exactly
// one result word. Once a word reaches the back end, the sequencer takes the word and
// classifies it. A tick loads a move from idle or chains to the next move where needed,
// checks for the end of the move, visits each axis, runs each stepping axis through the one
// shared threshold multiplier (twice when the step is rechecked) and updates the ramp.
// Every word then waits on the bit-serial period divider and the result is loaded. A
// two-word input queue accepts words while the back end works or its result waits,
// until it holds two. The move queue lives in RAM, needs no clearing pass after reset,
// and rejects moves with status 3 when full.
`default_nettype none
module linear_step_interpolator_ramp_top
	import lsi_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int POS_BITS    = POS_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [3:0]                   paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         req_type,
	input  wire logic signed [FIELD_BITS-1:0] target_x,
	input  wire logic signed [FIELD_BITS-1:0] target_y,
	input  wire logic signed [FIELD_BITS-1:0] target_z,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [1:0]                   status,
	output logic      [AXES-1:0]              step_mask,
	output logic      [AXES-1:0]              dir_mask,
	output logic                              drive_enable,
	output logic      [PERIOD_BITS-1:0]       tick_period,
	output logic signed [FIELD_BITS-1:0]      pos_x,
	output logic signed [FIELD_BITS-1:0]      pos_y,
	output logic signed [FIELD_BITS-1:0]      pos_z
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;
	item_t      in_item;
	item_t      item;
	logic       item_valid;
	logic       item_pop;
	result_t    res;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_min  <= SPEED_MIN_RST;
			cfg_q.speed_max  <= SPEED_MAX_RST;
			cfg_q.speed_step <= SPEED_STEP_RST;
			cfg_q.period_num <= PERIOD_NUM_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SPEED_MIN:  cfg_q.speed_min  <= pwdata[SPEED_BITS-1:0];
				REG_SPEED_MAX:  cfg_q.speed_max  <= pwdata[SPEED_BITS-1:0];
				REG_SPEED_STEP: cfg_q.speed_step <= pwdata[SSTEP_BITS-1:0];
				REG_PERIOD_NUM: cfg_q.period_num <= pwdata[PERIOD_BITS-1:0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	// Register read back
	always_comb begin
		unique case (reg_idx)
			REG_SPEED_MIN:  prdata = 32'(cfg_q.speed_min);
			REG_SPEED_MAX:  prdata = 32'(cfg_q.speed_max);
			REG_SPEED_STEP: prdata = 32'(cfg_q.speed_step);
			REG_PERIOD_NUM: prdata = 32'(cfg_q.period_num);
			default:        prdata = '0;
		endcase
	end

	assign in_item.req_type = req_type;
	assign in_item.target_x = target_x;
	assign in_item.target_y = target_y;
	assign in_item.target_z = target_z;

	lsi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.item       (item)
	);

	lsi_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.POS_BITS    (POS_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.item       (item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.res        (res)
	);

	assign status       = res.status;
	assign step_mask    = res.step_mask;
	assign dir_mask     = res.dir_mask;
	assign drive_enable = res.drive_enable;
	assign tick_period  = res.tick_period;
	assign pos_x        = res.pos_x;
	assign pos_y        = res.pos_y;
	assign pos_z        = res.pos_z;

endmodule
`default_nettype wire
